[sv/trt_pkg.sv]
// ----------------------------------------------------------------------------
// Timer and ramp table package
// Shared types and constants for the timer and ramp slot table.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int Slots     = 16;
  localparam int SlotW     = 4;
  localparam int TimeW     = 20;
  localparam int ValW      = 32;
  localparam int TimeGrain = 10;
  localparam int MinIntv   = 10;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START_P  = 3'd1,
    OP_START_O  = 3'd2,
    OP_START_R  = 3'd3,
    OP_PAUSE    = 3'd4,
    OP_RESUME   = 3'd5,
    OP_STOP     = 3'd6,
    OP_READ     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    K_FIRED    = 3'd0,
    K_RAMP     = 3'd1,
    K_TICKDONE = 3'd2,
    K_STARTED  = 3'd3,
    K_REJECTED = 3'd4,
    K_ACK      = 3'd5,
    K_READ     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    SK_PERIODIC = 2'd0,
    SK_ONESHOT  = 2'd1,
    SK_RAMP     = 2'd2
  } slot_kind_e;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [1:0]       skind;
    logic             wrap;
    logic [TimeW-1:0] reload;
    logic [TimeW-1:0] left;
    logic [ValW-1:0]  now;
    logic [ValW-1:0]  rstart;
    logic [ValW-1:0]  rend;
    logic [ValW-1:0]  rstep;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [2:0]       kind;
    logic [SlotW-1:0] result_slot;
    logic [ValW-1:0]  current_value;
    logic             completed;
    logic             found;
    logic [TimeW-1:0] next_wait_ms;
    logic             idle;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] elapsed_ms;
    logic [TimeW-1:0] interval_ms;
    logic [ValW-1:0]  start_value;
    logic [ValW-1:0]  end_value;
    logic [ValW-1:0]  step_value;
    logic             wraps;
  } item_t;

  // Rounds down to a multiple of the time grain by a reciprocal multiply and a single correction step.
  function automatic logic [TimeW-1:0] round_grain(input logic [TimeW-1:0] v);
    logic [TimeW-1:0] q;
    logic [TimeW+20:0] p;
    logic [TimeW-1:0] r;
    p = {21'd0, v} * 41'((1 << 20) / TimeGrain);
    q = p[TimeW+19:20];
    r = v - TimeW'(q * TimeW'(TimeGrain));
    if (r >= TimeW'(TimeGrain)) r = r - TimeW'(TimeGrain);
    round_grain = v - r;
  endfunction

endpackage

[sv/trt_if.sv]
// ----------------------------------------------------------------------------
// Item channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface trt_in_if import trt_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trt_out_if import trt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/trt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module trt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[sv/trt_ctrl.sv]
// ----------------------------------------------------------------------------
// Timer and ramp table control
// Sequencer that reads, updates and writes back slot entries.
// ----------------------------------------------------------------------------
module trt_ctrl import trt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  trt_in_if.sink           in_ch,
  trt_out_if.source        out_ch,
  output logic             we_o,
  output logic [SlotW-1:0] waddr_o,
  output entry_t           wdata_o,
  output logic [SlotW-1:0] raddr_o,
  input  entry_t           rdata_i
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_PROC = 5'b00100,
    S_EMIT = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [Slots-1:0] used_q, used_d;
  logic [Slots-1:0] paused_q, paused_d;
  item_t item_q;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [TimeW-1:0] elap_q, best_q, best_d;
  logic any_q, any_d;
  logic ovalid_q, ovalid_d;
  result_t res_q, res_d;

  logic [SlotW-1:0] free_idx;
  logic free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SlotW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic [ValW:0] sum;
  logic gt_end;
  logic ramp_done;
  logic [ValW-1:0] ramp_v;
  entry_t upd;
  logic fire;
  logic live;
  logic last_idx;

  assign live     = used_q[idx_q] && !paused_q[idx_q];
  assign fire     = live && (rdata_i.left <= elap_q);
  assign last_idx = (idx_q == SlotW'(Slots - 1));
  assign sum      = {rdata_i.now[ValW-1], rdata_i.now} + {rdata_i.rstep[ValW-1], rdata_i.rstep};
  assign gt_end   = $signed(sum) > $signed({rdata_i.rend[ValW-1], rdata_i.rend});
  assign ramp_done = gt_end && !rdata_i.wrap;

  always_comb begin
    if (gt_end) ramp_v = rdata_i.wrap ? rdata_i.rstart : rdata_i.rend;
    else if (sum[ValW] && !sum[ValW-1]) ramp_v = {1'b1, {(ValW-1){1'b0}}};
    else ramp_v = sum[ValW-1:0];
  end

  always_comb begin
    upd = rdata_i;
    if (!fire) upd.left = rdata_i.left - elap_q;
    else begin
      upd.left = rdata_i.reload;
      if (rdata_i.skind == SK_RAMP) upd.now = ramp_v;
    end
  end

  logic [TimeW-1:0] new_left;
  logic stays;
  assign new_left = upd.left;
  assign stays = live && !(fire && (rdata_i.skind == SK_ONESHOT ||
                 (rdata_i.skind == SK_RAMP && ramp_done)));

  logic [TimeW-1:0] iv;
  assign iv = round_grain(item_q.interval_ms);

  assign in_ch.ready = (state_q == S_IDLE) && !ovalid_q;
  assign out_ch.valid = ovalid_q;
  assign out_ch.data = res_q;
  assign raddr_o = idx_q;

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    paused_d = paused_q;
    idx_d    = idx_q;
    best_d   = best_q;
    any_d    = any_q;
    ovalid_d = ovalid_q && !out_ch.ready;
    res_d    = res_q;
    we_o     = 1'b0;
    waddr_o  = idx_q;
    wdata_o  = upd;
    case (state_q)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          idx_d = in_ch.data.slot;
          if (in_ch.data.op == OP_TICK) idx_d = '0;
          any_d = 1'b0;
          best_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_PROC;
        if (item_q.op != OP_TICK) state_d = S_DONE;
      end
      S_PROC: begin
        if (!ovalid_q || out_ch.ready) begin
          if (live) begin
            we_o = 1'b1;
            if (fire) begin
              ovalid_d = 1'b1;
              res_d = '0;
              res_d.result_slot = idx_q;
              if (rdata_i.skind == SK_RAMP) begin
                res_d.kind = K_RAMP;
                res_d.current_value = ramp_v;
                res_d.completed = ramp_done;
              end else begin
                res_d.kind = K_FIRED;
                res_d.completed = (rdata_i.skind == SK_ONESHOT);
              end
            end
            if (!stays) used_d[idx_q] = 1'b0;
            if (stays && (!any_q || new_left < best_q)) best_d = new_left;
            if (stays) any_d = 1'b1;
          end
          if (last_idx) state_d = S_EMIT;
          else begin
            idx_d = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_EMIT: begin
        if (!ovalid_q || out_ch.ready) begin
          ovalid_d = 1'b1;
          res_d = '0;
          res_d.kind = K_TICKDONE;
          res_d.next_wait_ms = any_q ? best_q : '0;
          res_d.idle = !any_q;
          res_d.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        ovalid_d = 1'b1;
        res_d = '0;
        res_d.last = 1'b1;
        res_d.result_slot = item_q.slot;
        state_d = S_IDLE;
        case (item_q.op)
          OP_START_P, OP_START_O, OP_START_R: begin
            res_d.result_slot = '0;
            if (item_q.interval_ms < TimeW'(MinIntv) || !free_any) begin
              res_d.kind = K_REJECTED;
            end else begin
              res_d.kind = K_STARTED;
              res_d.result_slot = free_idx;
              used_d[free_idx] = 1'b1;
              paused_d[free_idx] = 1'b0;
              we_o = 1'b1;
              waddr_o = free_idx;
              wdata_o = '0;
              wdata_o.reload = iv;
              wdata_o.left = iv;
              wdata_o.skind = SK_PERIODIC;
              if (item_q.op == OP_START_O) wdata_o.skind = SK_ONESHOT;
              if (item_q.op == OP_START_R) begin
                wdata_o.skind = SK_RAMP;
                wdata_o.wrap = item_q.wraps;
                wdata_o.now = item_q.start_value;
                wdata_o.rstart = item_q.start_value;
                wdata_o.rend = item_q.end_value;
                wdata_o.rstep = item_q.step_value;
              end
            end
          end
          OP_PAUSE, OP_RESUME: begin
            res_d.kind = K_ACK;
            res_d.found = used_q[item_q.slot];
            if (used_q[item_q.slot]) paused_d[item_q.slot] = (item_q.op == OP_PAUSE);
          end
          OP_STOP: begin
            res_d.kind = K_ACK;
            res_d.found = used_q[item_q.slot];
            used_d[item_q.slot] = 1'b0;
          end
          default: begin
            res_d.kind = K_READ;
            res_d.found = used_q[item_q.slot];
            if (used_q[item_q.slot] && rdata_i.skind == SK_RAMP)
              res_d.current_value = rdata_i.now;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      paused_q <= '0;
      idx_q    <= '0;
      any_q    <= 1'b0;
      best_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      paused_q <= paused_d;
      idx_q    <= idx_d;
      any_q    <= any_d;
      best_q   <= best_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_ch.valid && in_ch.ready) begin
      item_q <= in_ch.data;
      elap_q <= round_grain(in_ch.data.elapsed_ms);
    end
  end
endmodule

[sv/timer_and_ramp_table.sv]
// ----------------------------------------------------------------------------
// Timer and ramp table
// Sixteen slots of periodic timers, one-shot timers and value ramps.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   in_ch     sink       op, slot, elapsed_ms, interval_ms, ramp values, wraps
//   out_ch    source     kind, result_slot, current_value, flags, next_wait_ms
//
// A tick reads, updates and writes back each slot in turn through a read and
// a process state, then emits a tick-done result. Other items pass through a
// read and a done state. An item is taken only when idle with no result held.
// Reset clears the in-use and pause bits; memory contents need no clearing.
// A stalled result holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module timer_and_ramp_table import trt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  trt_in_if.sink   in_ch,
  trt_out_if.source out_ch
);
  logic             we;
  logic [SlotW-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  trt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_ch, .out_ch,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  trt_ram #(.Width(EntryW), .Depth(Slots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
endmodule

[sv/trt_checker.sv]
// ----------------------------------------------------------------------------
// Timer and ramp table checker
// Port-level properties of the input and result streams.
// ----------------------------------------------------------------------------
module trt_props import trt_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input result_t out_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");
  a_tickdone_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == K_TICKDONE |-> out_data_i.last)
    else $error("tick done not last");
  a_idle_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.idle |-> out_data_i.next_wait_ms == '0)
    else $error("idle with wait");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted while busy");
endmodule

bind timer_and_ramp_table trt_props u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data)
);

[dv/trt_checker.sv]
// ----------------------------------------------------------------------------
// Timer and ramp table checker
// Watches both channels of the timer and ramp table and predicts the result
// items of every accepted input item from its own copy of the slot table.
// Each accepted result item is compared, field by field, with the oldest
// expected one.
// ----------------------------------------------------------------------------
module trt_checker import trt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  trt_in_if    in_ch,
  trt_out_if   out_ch,
  output int   errors_o,
  output int   pending_o,
  output int   results_o,
  output int   firings_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                   used_q   [Slots];
  slot_kind_e             kind_q   [Slots];
  logic                   paused_q [Slots];
  logic                   wrap_q   [Slots];
  logic [TimeW-1:0]       reload_q [Slots];
  logic [TimeW-1:0]       left_q   [Slots];
  logic signed [ValW-1:0] now_q    [Slots];
  logic signed [ValW-1:0] rstart_q [Slots];
  logic signed [ValW-1:0] rend_q   [Slots];
  logic signed [ValW-1:0] rstep_q  [Slots];

  result_t expected_results[$];

  function automatic result_t make_result(kind_e k, int s, logic [ValW-1:0] v,
                                          logic c, logic f, logic [TimeW-1:0] w,
                                          logic i, logic l);
    result_t r;
    r.kind          = k;
    r.result_slot   = SlotW'(s);
    r.current_value = v;
    r.completed     = c;
    r.found         = f;
    r.next_wait_ms  = w;
    r.idle          = i;
    r.last          = l;
    return r;
  endfunction

  task automatic predict_tick(input logic [TimeW-1:0] raw);
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] best;
    logic             any;
    longint           v;
    logic             done;
    elapsed = raw - TimeW'(raw % TimeGrain);
    best = '0;
    any = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      if (!used_q[i] || paused_q[i]) continue;
      if (left_q[i] > elapsed) begin
        left_q[i] = left_q[i] - elapsed;
        continue;
      end
      if (kind_q[i] == SK_RAMP) begin
        v = longint'(now_q[i]) + longint'(rstep_q[i]);
        done = 1'b0;
        if (v > longint'(rend_q[i])) begin
          if (wrap_q[i]) begin
            v = longint'(rstart_q[i]);
          end else begin
            v = longint'(rend_q[i]);
            done = 1'b1;
          end
        end
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        now_q[i] = v[ValW-1:0];
        if (done) used_q[i] = 1'b0;
        else left_q[i] = reload_q[i];
        expected_results.push_back(make_result(K_RAMP, i, v[ValW-1:0], done, 0, 0, 0, 0));
      end else if (kind_q[i] == SK_ONESHOT) begin
        used_q[i] = 1'b0;
        expected_results.push_back(make_result(K_FIRED, i, 0, 1, 0, 0, 0, 0));
      end else begin
        left_q[i] = reload_q[i];
        expected_results.push_back(make_result(K_FIRED, i, 0, 0, 0, 0, 0, 0));
      end
    end
    for (int i = 0; i < Slots; i++) begin
      if (!used_q[i] || paused_q[i]) continue;
      if (!any || left_q[i] < best) best = left_q[i];
      any = 1'b1;
    end
    expected_results.push_back(make_result(K_TICKDONE, 0, 0, 0, 0,
                                           any ? best : '0, !any, 1));
  endtask

  task automatic predict_start(input item_t it, input slot_kind_e k);
    int s;
    s = -1;
    if (it.interval_ms < MinIntv) begin
      expected_results.push_back(make_result(K_REJECTED, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    for (int i = Slots - 1; i >= 0; i--) if (!used_q[i]) s = i;
    if (s < 0) begin
      expected_results.push_back(make_result(K_REJECTED, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    used_q[s]   = 1'b1;
    kind_q[s]   = k;
    paused_q[s] = 1'b0;
    reload_q[s] = it.interval_ms - TimeW'(it.interval_ms % TimeGrain);
    left_q[s]   = reload_q[s];
    if (k == SK_RAMP) begin
      rstart_q[s] = it.start_value;
      rend_q[s]   = it.end_value;
      rstep_q[s]  = it.step_value;
      now_q[s]    = it.start_value;
      wrap_q[s]   = it.wraps;
    end else begin
      rstart_q[s] = '0;
      rend_q[s]   = '0;
      rstep_q[s]  = '0;
      now_q[s]    = '0;
      wrap_q[s]   = 1'b0;
    end
    expected_results.push_back(make_result(K_STARTED, s, 0, 0, 0, 0, 0, 1));
  endtask

  task automatic predict_item(input item_t it);
    logic here;
    here = used_q[it.slot];
    case (op_e'(it.op))
      OP_TICK:    predict_tick(it.elapsed_ms);
      OP_START_P: predict_start(it, SK_PERIODIC);
      OP_START_O: predict_start(it, SK_ONESHOT);
      OP_START_R: predict_start(it, SK_RAMP);
      OP_PAUSE, OP_RESUME: begin
        if (here) paused_q[it.slot] = (op_e'(it.op) == OP_PAUSE);
        expected_results.push_back(make_result(K_ACK, it.slot, 0, 0, here, 0, 0, 1));
      end
      OP_STOP: begin
        if (here) used_q[it.slot] = 1'b0;
        expected_results.push_back(make_result(K_ACK, it.slot, 0, 0, here, 0, 0, 1));
      end
      default: begin
        expected_results.push_back(make_result(K_READ, it.slot,
                                               here ? now_q[it.slot] : '0,
                                               0, here, 0, 0, 1));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h",
               $realtime, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  task automatic check_result(input result_t act);
    result_t exp_r;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result item, actual %p", $realtime, act);
      errors_o++;
      return;
    end
    exp_r = expected_results.pop_front();
    check_field("kind", exp_r.kind, act.kind);
    check_field("result_slot", exp_r.result_slot, act.result_slot);
    check_field("current_value", exp_r.current_value, act.current_value);
    check_field("completed", exp_r.completed, act.completed);
    check_field("found", exp_r.found, act.found);
    check_field("next_wait_ms", exp_r.next_wait_ms, act.next_wait_ms);
    check_field("idle", exp_r.idle, act.idle);
    check_field("last", exp_r.last, act.last);
  endtask

  initial begin
    errors_o = 0;
    results_o = 0;
    firings_o = 0;
    for (int i = 0; i < Slots; i++) begin
      used_q[i] = 1'b0;
      paused_q[i] = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        results_o++;
        if (out_ch.data.kind inside {K_FIRED, K_RAMP}) firings_o++;
        check_result(out_ch.data);
      end
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.data);
    end
    pending_o = expected_results.size();
  end

  initial pending_o = 0;
endmodule

[dv/timer_and_ramp_table_tb.sv]
// ----------------------------------------------------------------------------
// Timer and ramp table testbench
// Drives directed and random items into the timer and ramp table with random
// gaps and result stalls, and lets the checker judge every result item.
// ----------------------------------------------------------------------------
module timer_and_ramp_table_tb import trt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   results;
  int   firings;
  int   cycles;
  int   items_sent;
  logic calm;

  trt_in_if  in_ch ();
  trt_out_if out_ch ();

  timer_and_ramp_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  trt_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results),
    .firings_o (firings)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("timer_and_ramp_table verification failed");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  function automatic item_t mk(op_e op, int s, logic [TimeW-1:0] el,
                               logic [TimeW-1:0] iv, logic [ValW-1:0] sv,
                               logic [ValW-1:0] ev, logic [ValW-1:0] st, logic w);
    item_t it;
    it.op = op;
    it.slot = SlotW'(s);
    it.elapsed_ms = el;
    it.interval_ms = iv;
    it.start_value = sv;
    it.end_value = ev;
    it.step_value = st;
    it.wraps = w;
    return it;
  endfunction

  task automatic send(input item_t it);
    if (!calm && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic item_t random_item();
    item_t it;
    logic [159:0] raw_bits;
    int pick;
    raw_bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw_bits[$bits(item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 28) begin
      it.op = OP_TICK;
      case ($urandom_range(9))
        0:       it.elapsed_ms = TimeW'($urandom);
        1, 2:    it.elapsed_ms = TimeW'($urandom_range(1000));
        default: it.elapsed_ms = TimeW'($urandom_range(150));
      endcase
    end else if (pick < 58) begin
      it.op = op_e'($urandom_range(OP_START_P, OP_START_R));
      case ($urandom_range(19))
        0:       it.interval_ms = TimeW'($urandom_range(9));
        1:       it.interval_ms = TimeW'($urandom);
        default: it.interval_ms = TimeW'($urandom_range(10, 300));
      endcase
      if ($urandom_range(1)) begin
        it.start_value = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        it.end_value = it.start_value + $urandom_range(0, 32'h0010_0000);
        it.step_value = $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
      end
    end else if (pick < 70) begin
      it.op = OP_STOP;
    end else if (pick < 85) begin
      it.op = op_e'($urandom_range(OP_PAUSE, OP_RESUME));
    end else begin
      it.op = OP_READ;
    end
    return it;
  endfunction

  initial begin
    items_sent = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_START_P, 0, 0, 9, 0, 0, 0, 0));
    send(mk(OP_START_P, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_START_O, 0, 0, 10, 0, 0, 0, 0));
    send(mk(OP_START_P, 0, 0, 25, 0, 0, 0, 0));
    send(mk(OP_START_R, 0, 0, 10, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0));
    send(mk(OP_START_R, 0, 0, 19, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1));
    send(mk(OP_START_R, 0, '1, '1, 32'hFFFF_FFFB, 32'h0000_0064, 32'h0000_0001, 1));
    send(mk(OP_READ, 3, 0, 0, 0, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_READ, 15, 0, 0, 0, 0, 0, 0));
    send(mk(OP_PAUSE, 1, 0, 0, 0, 0, 0, 0));
    send(mk(OP_PAUSE, 14, 0, 0, 0, 0, 0, 0));
    send(mk(OP_TICK, 0, 19, 0, 0, 0, 0, 0));
    send(mk(OP_RESUME, 1, 0, 0, 0, 0, 0, 0));
    send(mk(OP_RESUME, 14, 0, 0, 0, 0, 0, 0));
    send(mk(OP_TICK, 0, '1, 0, 0, 0, 0, 0));
    send(mk(OP_READ, 4, 0, 0, 0, 0, 0, 0));
    send(mk(OP_STOP, 4, 0, 0, 0, 0, 0, 0));
    send(mk(OP_STOP, 13, 0, 0, 0, 0, 0, 0));
    send(mk(OP_READ, 4, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < Slots + 1; i++)
      send(mk(OP_START_O, 0, 0, 10 + i, 0, 0, 0, 0));
    send(mk(OP_TICK, 0, 10, 0, 0, 0, 0, 0));

    for (int n = 0; n < 380; n++) begin
      calm = (n >= 150 && n < 230);
      send(random_item());
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d items and checked %0d result items, %0d of them timer or ramp firings.",
             items_sent, results, firings);
    if (errors == 0 && pending == 0) begin
      $display("timer_and_ramp_table verification clean");
    end else begin
      $display("timer_and_ramp_table verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/trt_pkg.sv
sv/trt_if.sv
sv/trt_ram.sv
sv/trt_ctrl.sv
sv/timer_and_ramp_table.sv
sv/trt_checker.sv
dv/trt_checker.sv
dv/timer_and_ramp_table_tb.sv
